>>> src/agc_pkg.sv
// ----------------------------------------------------------------------------
// agc_pkg: shared types and constants for the anagram group classifier
// Sizes of the letter signature and group table, op and status codes.
// ----------------------------------------------------------------------------
package agc_pkg;

  localparam int MaxGroups    = 64;
  localparam int MaxCount     = 255;
  localparam int AlphabetSize = 26;

  localparam int GidW  = 6;
  localparam int CntW  = 8;
  localparam int UsedW = 7;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_END   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_JOINED   = 2'd0,
    ST_NEW      = 2'd1,
    ST_FULL     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef logic [CntW-1:0] cnt_t;
  typedef cnt_t [AlphabetSize-1:0] sig_t;

  // One result item.
  typedef struct packed {
    logic [GidW-1:0] group_id;
    status_t         status;
  } result_t;

  // Control from the top level into each group cell.
  typedef struct packed {
    logic             wr_en;
    logic [GidW-1:0]  wr_idx;
    logic [UsedW-1:0] used;
  } cell_ctl_t;

endpackage

>>> src/agc_if.sv
// ----------------------------------------------------------------------------
// agc_in_if / agc_out_if: valid/ready channels of the classifier
// A transfer happens at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface agc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [4:0] letter;
  modport source (output valid, output op, output letter, input ready);
  modport sink   (input valid, input op, input letter, output ready);
endinterface

interface agc_out_if;
  logic                     valid;
  logic                     ready;
  logic [agc_pkg::GidW-1:0] group_id;
  logic [1:0]               status;
  modport source (output valid, output group_id, output status, input ready);
  modport sink   (input valid, input group_id, input status, output ready);
endinterface

>>> src/anagram_group_classifier.sv
// ----------------------------------------------------------------------------
// anagram_group_classifier: groups strings by letter-count signature
// Letter counting, group table match and result register.
// ----------------------------------------------------------------------------
// The block takes one item per cycle: add-letter items bump a saturating
// 8-bit count, end-of-string items compare the signature with every stored
// group in a row of 64 cells in the same cycle and give one result, clear
// items empty the table. The result register holds one result; input stalls
// only while that register is full and not being taken.
module anagram_group_classifier (
  input  logic      clk,
  input  logic      rst_n,
  agc_in_if.sink    in_ch,
  agc_out_if.source out_ch
);
  import agc_pkg::*;

  sig_t                      counts_r, counts_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [UsedW-1:0]          used_r, used_nxt;
  logic                      out_valid_r;
  result_t                   res_r, res_nxt;
  logic                      fire, end_fire;
  cell_ctl_t                 ctl;
  logic [MaxGroups:0]        hit_chain;
  logic [MaxGroups:0][GidW-1:0] idx_chain;
  op_t                       op;

  assign op           = op_t'(in_ch.op);
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign fire         = in_ch.valid && in_ch.ready;
  assign end_fire     = fire && op == OP_END;

  // Row of group cells
  assign hit_chain[0] = 1'b0;
  assign idx_chain[0] = '0;
  for (genvar g = 0; g < MaxGroups; g++) begin : g_cell
    agc_group_cell u_cell (
      .clk(clk), .cell_idx(GidW'(g)), .ctl(ctl), .cur_sig(counts_r),
      .hit_in(hit_chain[g]), .hit_idx_in(idx_chain[g]),
      .hit_out(hit_chain[g+1]), .hit_idx_out(idx_chain[g+1])
    );
  end

  // Classify and update the string state
  always_comb begin
    counts_nxt  = counts_r;
    ovf_nxt     = ovf_r;
    used_nxt    = used_r;
    res_nxt     = res_r;
    ctl.wr_en   = 1'b0;
    ctl.wr_idx  = used_r[GidW-1:0];
    ctl.used    = used_r;
    if (fire) begin
      unique case (op)
        OP_ADD: begin
          if (in_ch.letter < 5'(AlphabetSize)) begin
            if (counts_r[in_ch.letter] >= CntW'(MaxCount)) ovf_nxt = 1'b1;
            else counts_nxt[in_ch.letter] = counts_r[in_ch.letter] + 1'b1;
          end
        end
        OP_END: begin
          counts_nxt = '0;
          ovf_nxt    = 1'b0;
          if (ovf_r) begin
            res_nxt = '{group_id: '0, status: ST_OVERFLOW};
          end else if (hit_chain[MaxGroups]) begin
            res_nxt = '{group_id: idx_chain[MaxGroups], status: ST_JOINED};
          end else if (used_r < UsedW'(MaxGroups)) begin
            res_nxt   = '{group_id: used_r[GidW-1:0], status: ST_NEW};
            ctl.wr_en = 1'b1;
            used_nxt  = used_r + 1'b1;
          end else begin
            res_nxt = '{group_id: '0, status: ST_FULL};
          end
        end
        OP_CLEAR: begin
          counts_nxt = '0;
          ovf_nxt    = 1'b0;
          used_nxt   = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r    <= '0;
      ovf_r       <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      counts_r <= counts_nxt;
      ovf_r    <= ovf_nxt;
      used_r   <= used_nxt;
      if (end_fire) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_fire) res_r <= res_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.group_id = res_r.group_id;
  assign out_ch.status   = res_r.status;

endmodule

>>> src/agc_group_cell.sv
// ----------------------------------------------------------------------------
// agc_group_cell: one entry of the group table
// Holds one signature, compares it with the current string's signature and
// hands the lowest match index down the row.
// ----------------------------------------------------------------------------
module agc_group_cell (
  input  logic                      clk,
  input  logic [agc_pkg::GidW-1:0]  cell_idx,
  input  agc_pkg::cell_ctl_t        ctl,
  input  agc_pkg::sig_t             cur_sig,
  input  logic                      hit_in,
  input  logic [agc_pkg::GidW-1:0]  hit_idx_in,
  output logic                      hit_out,
  output logic [agc_pkg::GidW-1:0]  hit_idx_out
);
  import agc_pkg::*;

  sig_t sig_r;
  logic match;

  // Capture the signature when this entry opens a new group
  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_idx == cell_idx) begin
      sig_r <= cur_sig;
    end
  end

  // Match only live entries; keep an earlier hit from the row above
  assign match       = ({1'b0, cell_idx} < ctl.used) && (sig_r == cur_sig);
  assign hit_out     = hit_in || match;
  assign hit_idx_out = hit_in ? hit_idx_in : cell_idx;

endmodule

>>> src/agc_checker.sv
// ----------------------------------------------------------------------------
// agc_checker: port-level checks on the classifier
// Output handshake and result consistency.
// ----------------------------------------------------------------------------
module agc_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               in_op,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [agc_pkg::GidW-1:0] out_group_id,
  input logic [1:0]               out_status
);
  import agc_pkg::*;

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_group_id) && $stable(out_status))
    else $error("result changed under stall");

  // Input is ready whenever the output slot is free
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready) else $error("input stalled with empty output");

  // Full and overflow results carry group 0
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_OVERFLOW) |-> out_group_id == '0)
    else $error("nonzero group on full/overflow");

  // A new result appears only after an end-of-string transfer
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_op == OP_END))
    else $error("result without end of string");

endmodule

bind anagram_group_classifier agc_checker u_agc_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_group_id(out_ch.group_id), .out_status(out_ch.status)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the anagram group classifier
// Streams strings letter by letter, predicts group numbers and status from
// a local copy of the count signature and group table, and checks every
// result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  import agc_pkg::*;

  localparam int IdleLimit = 2000;

  logic clk;
  logic rst_n;

  agc_in_if  in_ch ();
  agc_out_if out_ch ();

  anagram_group_classifier i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the classifier state
  int      str_counts [AlphabetSize];
  bit      str_overflow;
  int      group_sig  [MaxGroups][AlphabetSize];
  int      groups_open;
  result_t pending_results [$];

  int errors;
  int idle_cycles;
  int burst_left;
  int stall_cycle;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic void clear_string();
    foreach (str_counts[i]) str_counts[i] = 0;
    str_overflow = 1'b0;
  endfunction

  // Apply one accepted item to the local state; queue a result on end of string
  function automatic void predict_item(op_t op, logic [4:0] letter);
    result_t r;
    case (op)
      OP_ADD: begin
        if (letter < AlphabetSize) begin
          if (str_counts[letter] >= MaxCount) str_overflow = 1'b1;
          else str_counts[letter]++;
        end
      end
      OP_CLEAR: begin
        clear_string();
        groups_open = 0;
      end
      OP_END: begin
        r.group_id = '0;
        if (str_overflow) begin
          r.status = ST_OVERFLOW;
        end else begin
          r.status = ST_FULL;
          for (int g = 0; g < groups_open; g++) begin
            if (group_sig[g] == str_counts) begin
              r.group_id = g[GidW-1:0];
              r.status   = ST_JOINED;
              break;
            end
          end
          if (r.status == ST_FULL && groups_open < MaxGroups) begin
            group_sig[groups_open] = str_counts;
            r.group_id = groups_open[GidW-1:0];
            r.status   = ST_NEW;
            groups_open++;
          end
        end
        clear_string();
        pending_results.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  // Send one item; bursts of random length separated by random gaps
  task automatic send_item(op_t op, logic [4:0] letter);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.letter <= letter;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(op, letter);
    @(negedge clk);
  endtask

  task automatic send_repeat(logic [4:0] letter, int n);
    repeat (n) send_item(OP_ADD, letter);
  endtask

  // Receiver stall pattern: steps through four ready modes in turn
  always @(negedge clk) begin
    stall_cycle++;
    case ((stall_cycle / 64) % 4)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= $urandom_range(0, 1);
      2: out_ch.ready <= (stall_cycle % 8 == 0);
      default: out_ch.ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check each result transfer and watch for a hang
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result gid=%0d status=%0d",
                         out_ch.group_id, out_ch.status));
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.group_id !== exp_r.group_id)
          report($sformatf("group_id %0d, expected %0d",
                           out_ch.group_id, exp_r.group_id));
        if (out_ch.status !== exp_r.status)
          report($sformatf("status %0d, expected %0d",
                           out_ch.status, exp_r.status));
      end
    end
    if (rst_n && !(out_ch.valid && out_ch.ready) && !(in_ch.valid && in_ch.ready))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles", IdleLimit);
      $display("FAILURE");
      $finish;
    end
  end

  // Empty strings, anagram pairs, ignored letters and op 3
  task automatic test_basic();
    send_item(OP_CLEAR, 5'd0);
    send_item(OP_END, 5'd0);
    send_item(OP_END, 5'd0);
    send_item(OP_ADD, 5'd0);
    send_item(OP_ADD, 5'd1);
    send_item(OP_END, 5'd0);
    send_item(OP_ADD, 5'd1);
    send_item(OP_ADD, 5'd0);
    send_item(OP_END, 5'd0);
    send_item(OP_ADD, 5'd25);
    send_item(OP_ADD, 5'd0);
    send_item(OP_END, 5'd0);
    send_item(OP_ADD, 5'd26);
    send_item(OP_ADD, 5'd31);
    send_item(OP_NOP, 5'd31);
    send_item(OP_END, 5'd31);
    send_item(OP_ADD, 5'd25);
    send_item(OP_ADD, 5'd0);
    send_item(OP_END, 5'd0);
  endtask

  // Saturate one count, then an empty string after the overflow
  task automatic test_overflow();
    send_item(OP_CLEAR, 5'd0);
    send_repeat(5'd7, MaxCount + 1);
    send_item(OP_END, 5'd0);
    send_item(OP_END, 5'd0);
  endtask

  // Fill every group slot, then one more new signature and a join
  task automatic test_table_full();
    send_item(OP_CLEAR, 5'd0);
    for (int g = 0; g <= MaxGroups; g++) begin
      send_repeat(5'(g % AlphabetSize), g / AlphabetSize + 1);
      send_item(OP_END, 5'd0);
    end
    send_repeat(5'd11, 3);
    send_item(OP_END, 5'd0);
    send_item(OP_CLEAR, 5'd0);
    send_item(OP_END, 5'd0);
  endtask

  // Mostly short strings over a few letters so anagrams recur
  task automatic test_random(int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 39) == 0) begin
        send_item(OP_CLEAR, 5'($urandom));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_item(($urandom_range(0, 1) != 0) ? OP_NOP : OP_ADD,
                  5'($urandom_range(AlphabetSize, 31)));
        sent++;
      end
      len = $urandom_range(0, 5);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0)
          send_item(OP_ADD, 5'($urandom_range(0, 31)));
        else
          send_item(OP_ADD, 5'($urandom_range(0, 3)));
      end
      send_item(OP_END, 5'($urandom));
      sent += len + 1;
    end
  endtask

  initial begin
    int wait_cycles;
    errors       = 0;
    idle_cycles  = 0;
    burst_left   = 0;
    stall_cycle  = 0;
    groups_open  = 0;
    clear_string();
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_NOP;
    in_ch.letter = '0;
    out_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic();
    test_overflow();
    test_table_full();
    test_random(140);
    in_ch.valid <= 1'b0;

    // Drain outstanding results
    wait_cycles = 0;
    while (pending_results.size() > 0 && wait_cycles < IdleLimit) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (10) @(posedge clk);
    if (pending_results.size() > 0)
      report($sformatf("%0d results never arrived", pending_results.size()));

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> anagram_group_classifier.f
src/agc_pkg.sv
src/agc_if.sv
src/agc_group_cell.sv
src/anagram_group_classifier.sv
src/agc_checker.sv
dv/tb.sv
